// ===== sv/assert_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define URC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define URC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== sv/urc_pkg.sv =====
// Shared types and constants of the ultrasonic ranger controller.
`default_nettype none

package urc_pkg;

  // Width of the tick counter (8 to 32).
  localparam int CntW     = 16;
  localparam int DelayW   = 16;
  localparam int TrigW    = 8;
  localparam int TickUsW  = 7;
  localparam int DivW     = 8;
  localparam int DistW    = 14;
  localparam int ProdW    = CntW + TickUsW;
  localparam int DivCntW  = $clog2(ProdW);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 8;
  localparam int OutDataW = 24;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgDelay     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTrigger   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTickUs    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDivisor   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 3'd4;

  // Register values after reset.
  localparam logic [DelayW-1:0]  RstDelay     = 16'd6000;
  localparam logic [TrigW-1:0]   RstTrigger   = 8'd1;
  localparam logic [TickUsW-1:0] RstTickUs    = 7'd10;
  localparam logic [DivW-1:0]    RstDivisor   = 8'd58;
  localparam logic [DistW-1:0]   RstThreshold = 14'd10;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2,
    PH_MEAS = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic [DelayW-1:0]  delay_ticks;
    logic [TrigW-1:0]   trigger_ticks;
    logic [TickUsW-1:0] tick_us;
    logic [DivW-1:0]    us_per_cm;
    logic [DistW-1:0]   alarm_threshold_cm;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic wait_inc;
    logic wait_clr;
    logic cnt_clr;
    logic cnt_adv;
    logic trig_set;
    logic trig_clr;
    logic rise_cap;
    logic width_load;
    logic mul_load;
    logic div_step;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic wait_hit;
    logic cnt_hit;
    logic rise;
    logic fall;
    logic trig_active;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/urc_datapath.sv =====
// Counters, captures, multiply and bit-serial divide of the ranger.
`default_nettype none

module urc_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire urc_pkg::cfg_t               cfg_i,
  input  wire urc_pkg::cmd_t               cmd_i,
  input  wire logic                        echo_i,
  output urc_pkg::sts_t                    sts_o,
  output logic [urc_pkg::DistW-1:0]        dist_o,
  output logic                             alarm_o
);

  logic [urc_pkg::DelayW-1:0] wait_q, wait_d, wait_nxt;
  logic [urc_pkg::CntW-1:0]   cnt_q, cnt_d, cnt_nxt;
  logic [urc_pkg::CntW-1:0]   rise_q, rise_d;
  logic [urc_pkg::CntW-1:0]   width_q, width_d;
  logic [urc_pkg::ProdW-1:0]  quo_q, quo_d;
  logic [urc_pkg::DivW-1:0]   rem_q, rem_d;
  logic [urc_pkg::DistW-1:0]  dist_q, dist_d, dist_new;
  logic                       trig_q, trig_d;
  logic                       echo_q, echo_d;
  logic                       alarm_q, alarm_d;
  logic [urc_pkg::DivW+1:0]   trial;

  assign wait_nxt = wait_q + urc_pkg::DelayW'(1);
  assign cnt_nxt  = cnt_q + urc_pkg::CntW'(1);

  assign sts_o.wait_hit    = (wait_nxt >= cfg_i.delay_ticks);
  assign sts_o.cnt_hit     = (cnt_nxt == urc_pkg::CntW'(cfg_i.trigger_ticks));
  assign sts_o.rise        = echo_i && !echo_q;
  assign sts_o.fall        = !echo_i && echo_q;
  assign sts_o.trig_active = trig_q;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign trial = {1'b0, rem_q, quo_q[urc_pkg::ProdW-1]} - {2'b00, cfg_i.us_per_cm};

  always_comb begin
    if (cfg_i.us_per_cm == '0) begin
      dist_new = urc_pkg::DistMax;
    end else if (|quo_q[urc_pkg::ProdW-1:urc_pkg::DistW]) begin
      dist_new = urc_pkg::DistMax;
    end else begin
      dist_new = quo_q[urc_pkg::DistW-1:0];
    end
  end

  always_comb begin
    wait_d  = wait_q;
    cnt_d   = cnt_q;
    rise_d  = rise_q;
    width_d = width_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dist_d  = dist_q;
    trig_d  = trig_q;
    echo_d  = echo_q;
    alarm_d = alarm_q;
    if (cmd_i.tick) begin
      echo_d = echo_i;
    end
    if (cmd_i.wait_clr) begin
      wait_d = '0;
    end else if (cmd_i.wait_inc) begin
      wait_d = wait_nxt;
    end
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_adv) begin
      cnt_d = cnt_nxt;
    end
    if (cmd_i.trig_set) begin
      trig_d = 1'b1;
    end else if (cmd_i.trig_clr) begin
      trig_d = 1'b0;
    end
    if (cmd_i.rise_cap) begin
      rise_d = cnt_q;
    end
    if (cmd_i.width_load) begin
      width_d = cnt_q - rise_q;
    end
    if (cmd_i.mul_load) begin
      quo_d = urc_pkg::ProdW'(width_q) * urc_pkg::ProdW'(cfg_i.tick_us);
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      quo_d = {quo_q[urc_pkg::ProdW-2:0], ~trial[urc_pkg::DivW+1]};
      if (!trial[urc_pkg::DivW+1]) begin
        rem_d = trial[urc_pkg::DivW-1:0];
      end else begin
        rem_d = {rem_q[urc_pkg::DivW-2:0], quo_q[urc_pkg::ProdW-1]};
      end
    end
    if (cmd_i.result_load) begin
      dist_d  = dist_new;
      alarm_d = (dist_new < cfg_i.alarm_threshold_cm);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q  <= '0;
      cnt_q   <= '0;
      rise_q  <= '0;
      dist_q  <= '0;
      trig_q  <= 1'b0;
      echo_q  <= 1'b0;
      alarm_q <= 1'b0;
    end else begin
      wait_q  <= wait_d;
      cnt_q   <= cnt_d;
      rise_q  <= rise_d;
      dist_q  <= dist_d;
      trig_q  <= trig_d;
      echo_q  <= echo_d;
      alarm_q <= alarm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q <= width_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
  end

  assign dist_o  = dist_q;
  assign alarm_o = alarm_q;

endmodule

`default_nettype wire

// ===== sv/urc_ctrl.sv =====
// Phase and sequencing state machine of the ranger.
`default_nettype none

module urc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_free_i,
  input  wire urc_pkg::sts_t sts_i,
  output urc_pkg::cmd_t      cmd_o,
  output logic               push_o,
  output logic               res_valid_o,
  output urc_pkg::phase_e    phase_o
);

  urc_pkg::state_e                state_q, state_d;
  urc_pkg::phase_e                phase_q, phase_d;
  logic [urc_pkg::DivCntW-1:0]    step_q, step_d;
  logic                           meas_q, meas_d;
  logic                           take;

  assign in_ready_o = (state_q == urc_pkg::ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    step_d      = step_q;
    meas_d      = meas_q;
    cmd_o       = '0;
    push_o      = 1'b0;
    case (state_q)
      urc_pkg::ST_IDLE: begin
        if (take) begin
          cmd_o.tick = 1'b1;
          state_d    = urc_pkg::ST_PUSH;
          case (phase_q)
            urc_pkg::PH_WAIT: begin
              if (!sts_i.trig_active) begin
                cmd_o.wait_inc = 1'b1;
                if (sts_i.wait_hit) begin
                  // start the trigger pulse, counter restarts at zero
                  cmd_o.wait_clr = 1'b1;
                  cmd_o.cnt_clr  = 1'b1;
                  cmd_o.trig_set = 1'b1;
                end else begin
                  cmd_o.cnt_adv = 1'b1;
                end
              end else begin
                cmd_o.cnt_adv = 1'b1;
                if (sts_i.cnt_hit) begin
                  cmd_o.trig_clr = 1'b1;
                  phase_d        = urc_pkg::PH_RISE;
                end
              end
            end
            urc_pkg::PH_RISE: begin
              cmd_o.cnt_adv = 1'b1;
              if (sts_i.rise) begin
                cmd_o.rise_cap = 1'b1;
                phase_d        = urc_pkg::PH_FALL;
              end
            end
            urc_pkg::PH_FALL: begin
              // freeze the counter on the falling edge
              if (sts_i.fall) begin
                phase_d = urc_pkg::PH_MEAS;
              end else begin
                cmd_o.cnt_adv = 1'b1;
              end
            end
            urc_pkg::PH_MEAS: begin
              cmd_o.width_load = 1'b1;
              cmd_o.cnt_adv    = 1'b1;
              cmd_o.wait_clr   = 1'b1;
              phase_d          = urc_pkg::PH_WAIT;
              meas_d           = 1'b1;
              state_d          = urc_pkg::ST_MUL;
            end
            default: begin
              phase_d = urc_pkg::PH_WAIT;
            end
          endcase
        end
      end
      urc_pkg::ST_MUL: begin
        cmd_o.mul_load = 1'b1;
        step_d         = urc_pkg::DivCntW'(urc_pkg::ProdW - 1);
        state_d        = urc_pkg::ST_DIV;
      end
      urc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q - urc_pkg::DivCntW'(1);
        if (step_q == '0) begin
          state_d = urc_pkg::ST_DONE;
        end
      end
      urc_pkg::ST_DONE: begin
        cmd_o.result_load = 1'b1;
        state_d           = urc_pkg::ST_PUSH;
      end
      urc_pkg::ST_PUSH: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          meas_d  = 1'b0;
          state_d = urc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = urc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= urc_pkg::ST_IDLE;
      phase_q <= urc_pkg::PH_WAIT;
      step_q  <= '0;
      meas_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      step_q  <= step_d;
      meas_q  <= meas_d;
    end
  end

  assign res_valid_o = meas_q;
  assign phase_o     = phase_q;

endmodule

`default_nettype wire

// ===== sv/ultrasonic_ranger_controller.sv =====
// Top level of the ultrasonic echo-ranging controller.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata[0] echo_level
//  m_axis    out  tvalid/tready          tdata: trigger_out, distance_cm, alarm_on,
//                                        phase_now; tuser: distance_valid
//  cfg       in   cfg_we_i (no wait)     cfg_idx_i register index, cfg_wdata_i value
//
// A tick is accepted, then its result goes into the output register once free.
// The measure tick adds a multiply step, then the bit-serial divider at one
// quotient bit per cycle, then a result load. Reset loads register defaults,
// clears ranging state but the multiply/divide registers; no clearing pass.
// One output register holds a result while the next tick is already accepted;
// a new result waits in the controller until that register drains.
`default_nettype none

module ultrasonic_ranger_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // slave side
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [urc_pkg::InDataW-1:0]   s_axis_tdata_i,  // [0] echo_level
  // master side
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [urc_pkg::OutDataW-1:0]       m_axis_tdata_o,  // [0] trigger_out,
                                                              // [14:1] distance_cm,
                                                              // [15] alarm_on,
                                                              // [17:16] phase_now
  output logic                               m_axis_tuser_o,  // [0] distance_valid
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [urc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [urc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  urc_pkg::cfg_t                      cfg_q, cfg_d;
  urc_pkg::cmd_t                      cmd;
  urc_pkg::sts_t                      sts;
  urc_pkg::phase_e                    phase;
  logic [urc_pkg::DistW-1:0]          range_cm;
  logic                               alarm;
  logic                               push;
  logic                               res_valid;
  logic                               out_free;
  logic                               out_valid_q, out_valid_d;
  logic [urc_pkg::OutDataW-1:0]       out_data_q, out_data_d;
  logic                               out_user_q, out_user_d;

  // Register writes: mask the data to each register's width, drop unknown indexes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        urc_pkg::CfgDelay:     cfg_d.delay_ticks        = cfg_wdata_i[urc_pkg::DelayW-1:0];
        urc_pkg::CfgTrigger:   cfg_d.trigger_ticks      = cfg_wdata_i[urc_pkg::TrigW-1:0];
        urc_pkg::CfgTickUs:    cfg_d.tick_us            = cfg_wdata_i[urc_pkg::TickUsW-1:0];
        urc_pkg::CfgDivisor:   cfg_d.us_per_cm          = cfg_wdata_i[urc_pkg::DivW-1:0];
        urc_pkg::CfgThreshold: cfg_d.alarm_threshold_cm = cfg_wdata_i[urc_pkg::DistW-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ticks        <= urc_pkg::RstDelay;
      cfg_q.trigger_ticks      <= urc_pkg::RstTrigger;
      cfg_q.tick_us            <= urc_pkg::RstTickUs;
      cfg_q.us_per_cm          <= urc_pkg::RstDivisor;
      cfg_q.alarm_threshold_cm <= urc_pkg::RstThreshold;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  urc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_free_i  (out_free),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .push_o      (push),
    .res_valid_o (res_valid),
    .phase_o     (phase)
  );

  urc_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .cmd_i   (cmd),
    .echo_i  (s_axis_tdata_i[0]),
    .sts_o   (sts),
    .dist_o  (range_cm),
    .alarm_o (alarm)
  );

  // Output register: free when empty or draining this cycle.
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_data_d  = {6'b0, phase, alarm, range_cm, sts.trig_active};
      out_user_d  = res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload only; valid alone carries the control.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire

// ===== sv/urc_checker.sv =====
// Port-level checks of the ranger, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module urc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [urc_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                         m_axis_tuser_o
);

  // A stalled result holds its payload.
  `URC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // One tick at a time: no accept right after an accept.
  `URC_ASSERT_NEXT(a_one_tick, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // A new distance comes with the block back in the wait phase.
  `URC_ASSERT_NOW(a_meas_phase, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o[17:16] == 2'd0)

  // The trigger is never high on a measurement result.
  `URC_ASSERT_NOW(a_meas_trig, m_axis_tvalid_o && m_axis_tuser_o, !m_axis_tdata_o[0])

endmodule

bind ultrasonic_ranger_controller urc_checker u_urc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// ===== verif/ranger_checker.sv =====
// Checker for the ranger controller: tick predictor and report scoreboard.
`timescale 1ns / 1ps

module ranger_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  input  wire logic                         s_axis_tready_i,
  input  wire logic [urc_pkg::InDataW-1:0]  s_axis_tdata_i,   // [0] echo_level
  input  wire logic                         m_axis_tvalid_i,
  input  wire logic                         m_axis_tready_i,
  input  wire logic [urc_pkg::OutDataW-1:0] m_axis_tdata_i,   // [0] trigger_out,
                                                              // [14:1] distance_cm,
                                                              // [15] alarm_on,
                                                              // [17:16] phase_now
  input  wire logic                         m_axis_tuser_i,   // [0] distance_valid
  input  wire logic                         cfg_we_i,
  input  wire logic [urc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [urc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                                errors_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                measured_o,
  output int                                alarmed_o
);

  typedef struct packed {
    logic                      trigger;
    logic [urc_pkg::DistW-1:0] distance;
    logic                      valid;
    logic                      alarm;
    logic [1:0]                phase;
  } report_t;

  // Shadow registers and ranging state.
  urc_pkg::cfg_t              shadow_cfg;
  urc_pkg::phase_e            phase_q;
  logic [urc_pkg::DelayW-1:0] wait_q;
  logic [urc_pkg::CntW-1:0]   cnt_q;
  logic                       trig_q;
  logic [urc_pkg::CntW-1:0]   rise_q;
  logic                       echo_q;
  logic [urc_pkg::DistW-1:0]  dist_q;
  logic                       alarm_q;

  report_t expected_reports[$];
  report_t seen_report;
  report_t due_report;
  report_t next_report;

  task automatic clear_ranger();
    shadow_cfg.delay_ticks        = urc_pkg::RstDelay;
    shadow_cfg.trigger_ticks      = urc_pkg::RstTrigger;
    shadow_cfg.tick_us            = urc_pkg::RstTickUs;
    shadow_cfg.us_per_cm          = urc_pkg::RstDivisor;
    shadow_cfg.alarm_threshold_cm = urc_pkg::RstThreshold;
    phase_q = urc_pkg::PH_WAIT;
    wait_q  = '0;
    cnt_q   = '0;
    trig_q  = 1'b0;
    rise_q  = '0;
    echo_q  = 1'b0;
    dist_q  = '0;
    alarm_q = 1'b0;
  endtask

  // Advance the ranging state by one tick and form the report it causes.
  task automatic advance_ranger(input logic echo, output report_t rep);
    logic                      rise_edge;
    logic                      fall_edge;
    logic                      count_on;
    logic [urc_pkg::CntW-1:0]  span;
    logic [urc_pkg::ProdW-1:0] span_us;
    logic [urc_pkg::ProdW-1:0] quot;
    rise_edge = echo & ~echo_q;
    fall_edge = ~echo & echo_q;
    count_on  = 1'b1;
    rep.valid = 1'b0;
    case (phase_q)
      urc_pkg::PH_WAIT: begin
        if (!trig_q) begin
          wait_q = wait_q + 1'b1;
          if (wait_q >= shadow_cfg.delay_ticks) begin
            wait_q   = '0;
            cnt_q    = '0;
            trig_q   = 1'b1;
            count_on = 1'b0;
          end
        end else begin
          cnt_q    = cnt_q + 1'b1;
          count_on = 1'b0;
          if (cnt_q == shadow_cfg.trigger_ticks) begin
            trig_q  = 1'b0;
            phase_q = urc_pkg::PH_RISE;
          end
        end
      end
      urc_pkg::PH_RISE: begin
        if (rise_edge) begin
          rise_q  = cnt_q;
          phase_q = urc_pkg::PH_FALL;
        end
      end
      urc_pkg::PH_FALL: begin
        if (fall_edge) begin
          count_on = 1'b0;
          phase_q  = urc_pkg::PH_MEAS;
        end
      end
      default: begin
        span    = cnt_q - rise_q;
        span_us = span * shadow_cfg.tick_us;
        if (shadow_cfg.us_per_cm == '0) begin
          dist_q = urc_pkg::DistMax;
        end else begin
          quot   = span_us / shadow_cfg.us_per_cm;
          dist_q = (quot > urc_pkg::DistMax) ? urc_pkg::DistMax : quot[urc_pkg::DistW-1:0];
        end
        alarm_q   = (dist_q < shadow_cfg.alarm_threshold_cm);
        rep.valid = 1'b1;
        wait_q    = '0;
        phase_q   = urc_pkg::PH_WAIT;
      end
    endcase
    if (count_on) cnt_q = cnt_q + 1'b1;
    echo_q       = echo;
    rep.trigger  = trig_q;
    rep.distance = dist_q;
    rep.alarm    = alarm_q;
    rep.phase    = phase_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_ranger();
      expected_reports.delete();
      errors_o   = 0;
      pending_o  = 0;
      checked_o  = 0;
      measured_o = 0;
      alarmed_o  = 0;
    end else begin
      // Mirror register writes; unknown indexes drop silently.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          urc_pkg::CfgDelay:
            shadow_cfg.delay_ticks = cfg_wdata_i[urc_pkg::DelayW-1:0];
          urc_pkg::CfgTrigger:
            shadow_cfg.trigger_ticks = cfg_wdata_i[urc_pkg::TrigW-1:0];
          urc_pkg::CfgTickUs:
            shadow_cfg.tick_us = cfg_wdata_i[urc_pkg::TickUsW-1:0];
          urc_pkg::CfgDivisor:
            shadow_cfg.us_per_cm = cfg_wdata_i[urc_pkg::DivW-1:0];
          urc_pkg::CfgThreshold:
            shadow_cfg.alarm_threshold_cm = cfg_wdata_i[urc_pkg::DistW-1:0];
          default: ;
        endcase
      end
      // Compare a report against the oldest expectation before queuing new ones.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen_report.trigger  = m_axis_tdata_i[0];
        seen_report.distance = m_axis_tdata_i[urc_pkg::DistW:1];
        seen_report.alarm    = m_axis_tdata_i[urc_pkg::DistW+1];
        seen_report.phase    = m_axis_tdata_i[urc_pkg::DistW+3:urc_pkg::DistW+2];
        seen_report.valid    = m_axis_tuser_i;
        checked_o++;
        if (seen_report.valid) begin
          measured_o++;
          if (seen_report.alarm) alarmed_o++;
        end
        if (expected_reports.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected report trig=%0b dist=%0d valid=%0b alarm=%0b ph=%0d",
                     $realtime, seen_report.trigger, seen_report.distance, seen_report.valid,
                     seen_report.alarm, seen_report.phase);
        end else begin
          due_report = expected_reports.pop_front();
          if (seen_report != due_report) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: mismatch exp trig=%0b dist=%0d valid=%0b alarm=%0b ph=%0d",
                       $realtime, due_report.trigger, due_report.distance, due_report.valid,
                       due_report.alarm, due_report.phase);
              $display("          got trig=%0b dist=%0d valid=%0b alarm=%0b ph=%0d",
                       seen_report.trigger, seen_report.distance, seen_report.valid,
                       seen_report.alarm, seen_report.phase);
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        advance_ranger(s_axis_tdata_i[0], next_report);
        expected_reports.push_back(next_report);
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

// ===== verif/tb_ultrasonic_ranger_controller.sv =====
// Testbench top for the ultrasonic ranger controller: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_ultrasonic_ranger_controller;

  localparam int CycleLimit   = 2_000_000;
  localparam int RandPhases   = 6;
  localparam int RandItems    = 650;
  localparam int SettleCycles = 40;

  logic                         clk;
  logic                         rst_n;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [urc_pkg::InDataW-1:0]  s_tdata;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [urc_pkg::OutDataW-1:0] m_tdata;
  logic                         m_tuser;
  logic                         cfg_we;
  logic [urc_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [urc_pkg::CfgDataW-1:0] cfg_wdata;

  int errors;
  int pending;
  int checked;
  int measured;
  int alarmed;

  int  ticks_sent;
  int  settings_count;
  int  cycles;
  // Enables random idling bursts on both channels.
  logic gaps_on;

  ultrasonic_ranger_controller u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [0] echo_level
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [0] trigger_out, [14:1] distance_cm,
                                  // [15] alarm_on, [17:16] phase_now
    .m_axis_tuser_o  (m_tuser),   // [0] distance_valid
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  ranger_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [0] echo_level
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),   // [0] trigger_out, [14:1] distance_cm,
                                  // [15] alarm_on, [17:16] phase_now
    .m_axis_tuser_i  (m_tuser),   // [0] distance_valid
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked),
    .measured_o      (measured),
    .alarmed_o       (alarmed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run once the cycle limit is reached.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d reports outstanding", cycles, pending);
    $display("DONE: errors detected");
    $finish;
  end

  // Report receiver: drop tready in random bursts while idling is enabled.
  initial begin
    m_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Present one tick with the given echo level and hold it until the transaction
  // completes. Called and returns at a falling edge, tvalid still high.
  task automatic send_tick(input logic echo);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(urc_pkg::InDataW-1){1'b0}}, echo};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic echo, input int n);
    for (int k = 0; k < n; k++) send_tick(echo);
  endtask

  // Send n ticks, echo levels taken from bits, lowest bit first.
  task automatic send_bits(input logic [31:0] bits, input int n);
    for (int k = 0; k < n; k++) send_tick(bits[k]);
  endtask

  // Stop sending and hold until every outstanding report has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write all five registers with raw port words (the block masks them), plus
  // one write to an unused index that must leave everything alone.
  task automatic program_regs(input logic [urc_pkg::CfgDataW-1:0] dly,
                              input logic [urc_pkg::CfgDataW-1:0] trg,
                              input logic [urc_pkg::CfgDataW-1:0] tus,
                              input logic [urc_pkg::CfgDataW-1:0] div,
                              input logic [urc_pkg::CfgDataW-1:0] thr);
    logic [urc_pkg::CfgDataW-1:0] words [urc_pkg::CfgThreshold+1];
    words[urc_pkg::CfgDelay]     = dly;
    words[urc_pkg::CfgTrigger]   = trg;
    words[urc_pkg::CfgTickUs]    = tus;
    words[urc_pkg::CfgDivisor]   = div;
    words[urc_pkg::CfgThreshold] = thr;
    cfg_we    <= 1'b1;
    cfg_idx   <= urc_pkg::CfgIdxW'($urandom_range(urc_pkg::CfgThreshold + 1,
                                                  (1 << urc_pkg::CfgIdxW) - 1));
    cfg_wdata <= urc_pkg::CfgDataW'($urandom);
    @(negedge clk);
    for (int i = urc_pkg::CfgDelay; i <= urc_pkg::CfgThreshold; i++) begin
      cfg_idx   <= urc_pkg::CfgIdxW'(i);
      cfg_wdata <= words[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  initial begin
    int dly;
    int trg;
    int div;
    int thr;
    int budget;
    int lead;
    int len;
    int n;

    rst_n          = 1'b0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    gaps_on        = 1'b1;
    ticks_sent     = 0;
    settings_count = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: a few ticks on the reset settings; the long default delay
    // keeps the block waiting.
    send_bits(32'b010, 3);
    drain();

    // Zero delay acts as one; zero tick length gives distance 0. The echo is
    // already high when the block starts awaiting the rise, so that level must
    // not count as an edge; the later pulse is measured. Threshold at minimum.
    program_regs(16'd0, 16'd1, 16'd0, 16'd58, 16'd0);
    send_bits(32'b0011_0111, 8);
    drain();

    // Zero divisor saturates. Upper bits of tick_us and threshold words are
    // junk that the register width must mask off (100 and 16383 remain).
    program_regs(16'd1, 16'd1, 16'h80E4, 16'd0, 16'hFFFF);
    send_bits(32'b00100, 5);
    drain();

    // Every register at its top value; the delay is far too long to trigger.
    program_regs(16'hFFFF, 16'hFF, 16'h007F, 16'hFF, 16'h3FFF);
    send_bits($urandom, 4);
    drain();

    // Zero trigger length: the trigger holds high while the counter climbs.
    // A trigger length of 12 then releases it, and a five-tick echo gives
    // 50 cm at 10 us, divisor 1, alarm below 60.
    program_regs(16'd1, 16'd0, 16'd10, 16'd1, 16'd60);
    send_run(1'b0, 10);
    drain();
    program_regs(16'd1, 16'd12, 16'd10, 16'd1, 16'd60);
    send_run(1'b0, 5);
    send_run(1'b1, 5);
    send_run(1'b0, 3);
    drain();

    // Random part: each phase gets fresh settings, then mostly well-formed
    // ping cycles (low lead-in sized to the expected wait and trigger, then an
    // echo pulse), some with an early rise, mixed with bursts of noise.
    for (int ph = 0; ph < RandPhases; ph++) begin
      dly = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      trg = (ph == 2) ? 255 : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) div = 0;
      else if ($urandom_range(0, 1) == 0) div = $urandom_range(1, 20);
      else div = $urandom_range(1, 255);
      thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
      // No idling at all in the last phase.
      gaps_on = (ph != RandPhases - 1) && ($urandom_range(0, 3) != 0);
      program_regs(urc_pkg::CfgDataW'(dly), urc_pkg::CfgDataW'(trg),
                   urc_pkg::CfgDataW'($urandom), urc_pkg::CfgDataW'(div),
                   urc_pkg::CfgDataW'(thr));
      budget = RandItems / RandPhases;
      while (budget > 0) begin
        if ($urandom_range(0, 5) == 0) begin
          n = $urandom_range(1, 8);
          send_bits($urandom, n);
          budget -= n;
        end else begin
          // Lead-in covers the fall tick, the measure tick, the wait and the trigger.
          lead = 2 + ((dly == 0) ? 1 : dly) + trg + $urandom_range(0, 3);
          if ($urandom_range(0, 7) == 0) lead = $urandom_range(1, lead);
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
          send_run(1'b0, lead);
          send_run(1'b1, len);
          budget -= lead + len;
        end
      end
      drain();
    end

    repeat (SettleCycles) @(posedge clk);
    $display("Sent %0d echo ticks over %0d register settings (zero delay, trigger, tick, divisor).",
             ticks_sent, settings_count);
    $display("Checked %0d reports, %0d with a new distance, %0d of those raising the alarm.",
             checked, measured, alarmed);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
